>>> rtl/rtt_fd_pkg.sv
// Shared widths, constants and sequencer states for the RTT fairness delay block.
package rtt_fd_pkg;

    // Run limits and field widths
    localparam int MAX_PEERS = 64;
    localparam int RTT_W     = 17;
    localparam int MAG_W     = 16;
    localparam int CNT_W     = 7;
    localparam int TOT_W     = 23;
    localparam int SQT_W     = 39;
    localparam int FRAC_W    = 16;

    // Datapath widths of the serial units
    localparam int DIG_W     = 4;
    localparam int SQA_W     = MAG_W + 3 * DIG_W;
    localparam int DIVQ_W    = 78;
    localparam int DIVD_W    = 16;
    localparam int WACC_W    = 47;
    localparam int MB_W      = 23;
    localparam int ROOT_W    = 64;
    localparam int STEP_W    = 7;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONG_USERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_UNIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY  = 2'd3;

    // Register reset values
    localparam logic [7:0]  DELAY_UNIT_RST = 8'd10;
    localparam logic [15:0] MAX_DELAY_RST  = 16'd1000;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_MEAN_DIV,
        ST_MUL_NS,
        ST_MUL_TT,
        ST_VAR_DIV,
        ST_SQRT,
        ST_THRESH,
        ST_MUL_W,
        ST_DLY_DIV,
        ST_RESULT
    } fd_state_t;

endpackage

>>> rtl/rtt_fairness_delay.sv
// Hold-back delay for a target peer from a run of per-peer round-trip times.
//
// Input items arrive on s_axis_*: tdata[16:0] is the signed round-trip time,
// tuser[0] flags the item as a statistics sample, tuser[1] marks the target,
// tlast ends the run. Each run ends in exactly one result on m_axis_*:
// tdata[15:0] is the delay in ms, tuser[0] says the target was throttled.
// Registers are written on the cfg_* channel, which is always ready.
// A sample item is accepted and then its square is built in 4-bit digits
// by a shift-and-add unit before the next item is taken. Other items need
// only the accept. After the last item a bit-serial sequencer forms the
// result in order: mean divide, n*sumsq, minus total^2, variance divide,
// square root, weight product and delay divide; the last two run only
// when the target is throttled.
// Runs with no sample or zero weight skip the arithmetic: the check step
// passes straight to the result step.
// The result sits in an output register; the block goes on to accept the
// next run while it waits, and stalls in its last step only if a second
// result is ready before the first is taken.
// Reset clears the run state, sets the target time to 1 and loads the
// register defaults; no result is pending after reset.
module rtt_fairness_delay
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [23:0]                          s_axis_tdata,  // rtt_ms[16:0], zero pad
    input  logic [1:0]                           s_axis_tuser,  // in_stats, is_target
    input  logic                                 s_axis_tlast,  // last_peer
    // Result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // delay_ms[15:0]
    output logic [0:0]                           m_axis_tuser,  // throttled
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rtt_fd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtt_fd_pkg::CFG_DAT_W-1:0]     cfg_data
);

    rtt_fd_pkg::fd_state_t state_reg, state_next;

    // Configuration registers
    logic        cong_mode_reg;
    logic [6:0]  cong_users_reg;
    logic [7:0]  delay_unit_reg;
    logic [15:0] max_delay_reg;

    // Run state
    logic [rtt_fd_pkg::CNT_W-1:0]  count_reg;
    logic [rtt_fd_pkg::TOT_W-1:0]  total_reg;
    logic [rtt_fd_pkg::SQT_W-1:0]  sqsum_reg;
    logic [rtt_fd_pkg::MAG_W-1:0]  target_reg;
    logic                          last_pend_reg;

    // Square unit
    logic [rtt_fd_pkg::SQA_W-1:0]  sqa_reg;
    logic [rtt_fd_pkg::MAG_W-1:0]  sqb_reg;

    // Shared step counter
    logic [rtt_fd_pkg::STEP_W-1:0] step_reg;

    // Serial multiplier
    logic [rtt_fd_pkg::WACC_W-1:0] wacc_reg;
    logic [rtt_fd_pkg::WACC_W-1:0] msh_reg;
    logic [rtt_fd_pkg::MB_W-1:0]   mbits_reg;

    // Restoring divider
    logic [rtt_fd_pkg::DIVQ_W-1:0] divq_reg;
    logic [rtt_fd_pkg::DIVD_W-1:0] rem_reg;
    logic [rtt_fd_pkg::DIVD_W-1:0] divisor_reg;

    // Square root unit
    logic [rtt_fd_pkg::ROOT_W-1:0] sqv_reg;
    logic [rtt_fd_pkg::ROOT_W-1:0] sqres_reg;
    logic [rtt_fd_pkg::ROOT_W-1:0] sqbit_reg;

    // Intermediate results
    logic [13:0] nn_reg;
    logic [14:0] wu_reg;
    logic [31:0] mean_reg;
    logic [31:0] dev_reg;
    logic [15:0] res_delay_reg;
    logic        res_thr_reg;

    // Output register
    logic        out_valid_reg;
    logic [15:0] out_delay_reg;
    logic        out_thr_reg;

    // Handshake and control
    logic        in_accept;
    logic        take_sample;
    logic        out_free;
    logic        out_load;
    logic        step_done;

    // Input decode
    logic                         in_neg;
    logic [rtt_fd_pkg::MAG_W-1:0] in_mag;
    logic [rtt_fd_pkg::MAG_W-1:0] in_sample;

    // Combinational step values
    logic [31:0]                   sq_part;
    logic [6:0]                    weight;
    logic                          zero_case;
    logic [rtt_fd_pkg::WACC_W-1:0] wacc_step;
    logic [rtt_fd_pkg::DIVD_W:0]   div_shift;
    logic                          div_ge;
    logic [rtt_fd_pkg::DIVD_W:0]   div_diff;
    logic [rtt_fd_pkg::DIVD_W-1:0] rem_step;
    logic [rtt_fd_pkg::DIVQ_W-1:0] divq_step;
    logic [rtt_fd_pkg::ROOT_W-1:0] sq_sum;
    logic                          sq_ge;
    logic [rtt_fd_pkg::ROOT_W-1:0] sqv_step;
    logic [rtt_fd_pkg::ROOT_W-1:0] sqres_step;
    logic [32:0]                   thr;
    logic [32:0]                   tgt_q16;
    logic                          throttle;
    logic [30:0]                   dly_q;
    logic [15:0]                   dly_capped;

    // Decode the input item
    assign in_neg    = s_axis_tdata[rtt_fd_pkg::RTT_W-1];
    assign in_mag    = s_axis_tdata[rtt_fd_pkg::MAG_W-1:0];
    assign in_sample = in_neg ? '0 : in_mag;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign take_sample = in_accept && s_axis_tuser[0]
        && (count_reg < rtt_fd_pkg::CNT_W'(rtt_fd_pkg::MAX_PEERS));

    assign step_done = (step_reg == '0);
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Form one digit product of the square
    assign sq_part = 32'(sqa_reg) * 32'(sqb_reg[rtt_fd_pkg::DIG_W-1:0]);

    // Pick the weight and spot the runs that yield zero
    assign weight    = cong_mode_reg ? cong_users_reg : 7'd1;
    assign zero_case = (count_reg == '0) || (weight == '0);

    // Step the shift-and-add multiplier; total^2 is taken off n*sumsq
    always_comb
    begin
        wacc_step = wacc_reg;
        if (mbits_reg[0])
        begin
            if (state_reg == rtt_fd_pkg::ST_MUL_TT)
            begin
                wacc_step = wacc_reg - msh_reg;
            end
            else
            begin
                wacc_step = wacc_reg + msh_reg;
            end
        end
    end

    // Step the restoring divider by one quotient bit
    assign div_shift = {rem_reg, divq_reg[rtt_fd_pkg::DIVQ_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_diff  = div_shift - {1'b0, divisor_reg};
    assign rem_step  = div_ge ? div_diff[rtt_fd_pkg::DIVD_W-1:0]
                              : div_shift[rtt_fd_pkg::DIVD_W-1:0];
    assign divq_step = {divq_reg[rtt_fd_pkg::DIVQ_W-2:0], div_ge};

    // Step the square root by one result bit
    assign sq_sum     = sqres_reg + sqbit_reg;
    assign sq_ge      = (sqv_reg >= sq_sum);
    assign sqv_step   = sq_ge ? (sqv_reg - sq_sum) : sqv_reg;
    assign sqres_step = sq_ge ? ((sqres_reg >> 1) + sqbit_reg) : (sqres_reg >> 1);

    // Compare target against threshold
    assign thr      = {1'b0, mean_reg} - {1'b0, dev_reg};
    assign tgt_q16  = {1'b0, target_reg, 16'd0};
    assign throttle = !thr[32] && (tgt_q16 <= thr);

    // Cap the delay
    assign dly_q      = divq_step[30:0];
    assign dly_capped = (dly_q > {15'd0, max_delay_reg}) ? max_delay_reg : dly_q[15:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtt_fd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (take_sample)
                    begin
                        state_next = rtt_fd_pkg::ST_SQUARE;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = rtt_fd_pkg::ST_CHECK;
                    end
                end
            end
            rtt_fd_pkg::ST_SQUARE:
            begin
                if (step_done)
                begin
                    state_next = last_pend_reg ? rtt_fd_pkg::ST_CHECK : rtt_fd_pkg::ST_IDLE;
                end
            end
            rtt_fd_pkg::ST_CHECK:
            begin
                state_next = zero_case ? rtt_fd_pkg::ST_RESULT : rtt_fd_pkg::ST_MEAN_DIV;
            end
            rtt_fd_pkg::ST_MEAN_DIV:
            begin
                if (step_done)
                begin
                    state_next = rtt_fd_pkg::ST_MUL_NS;
                end
            end
            rtt_fd_pkg::ST_MUL_NS:
            begin
                if (step_done)
                begin
                    state_next = rtt_fd_pkg::ST_MUL_TT;
                end
            end
            rtt_fd_pkg::ST_MUL_TT:
            begin
                if (step_done)
                begin
                    state_next = rtt_fd_pkg::ST_VAR_DIV;
                end
            end
            rtt_fd_pkg::ST_VAR_DIV:
            begin
                if (step_done)
                begin
                    state_next = rtt_fd_pkg::ST_SQRT;
                end
            end
            rtt_fd_pkg::ST_SQRT:
            begin
                if (step_done)
                begin
                    state_next = rtt_fd_pkg::ST_THRESH;
                end
            end
            rtt_fd_pkg::ST_THRESH:
            begin
                state_next = throttle ? rtt_fd_pkg::ST_MUL_W : rtt_fd_pkg::ST_RESULT;
            end
            rtt_fd_pkg::ST_MUL_W:
            begin
                if (step_done)
                begin
                    state_next = rtt_fd_pkg::ST_DLY_DIV;
                end
            end
            rtt_fd_pkg::ST_DLY_DIV:
            begin
                if (step_done)
                begin
                    state_next = rtt_fd_pkg::ST_RESULT;
                end
            end
            rtt_fd_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = rtt_fd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtt_fd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            rtt_fd_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            rtt_fd_pkg::ST_RESULT:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
                out_load      = 1'b0;
            end
        endcase
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_delay_reg;
    assign m_axis_tuser  = out_thr_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtt_fd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cong_mode_reg  <= 1'b0;
            cong_users_reg <= '0;
            delay_unit_reg <= rtt_fd_pkg::DELAY_UNIT_RST;
            max_delay_reg  <= rtt_fd_pkg::MAX_DELAY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rtt_fd_pkg::REG_CONG_MODE:  cong_mode_reg  <= cfg_data[0];
                rtt_fd_pkg::REG_CONG_USERS: cong_users_reg <= cfg_data[6:0];
                rtt_fd_pkg::REG_DELAY_UNIT: delay_unit_reg <= cfg_data[7:0];
                rtt_fd_pkg::REG_MAX_DELAY:  max_delay_reg  <= cfg_data[15:0];
                default:                    max_delay_reg  <= max_delay_reg;
            endcase
        end
    end

    // Accumulate the run; clear it when the result is loaded into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            sqsum_reg     <= '0;
            target_reg    <= 16'd1;
            last_pend_reg <= 1'b0;
        end
        else if (out_load)
        begin
            count_reg  <= '0;
            total_reg  <= '0;
            sqsum_reg  <= '0;
            target_reg <= 16'd1;
        end
        else
        begin
            if (in_accept)
            begin
                last_pend_reg <= s_axis_tlast;
                if (s_axis_tuser[1])
                begin
                    target_reg <= (in_neg || (in_mag == '0)) ? 16'd1 : in_mag;
                end
            end
            if (take_sample)
            begin
                count_reg <= count_reg + 1'b1;
                total_reg <= total_reg + rtt_fd_pkg::TOT_W'(in_sample);
            end
            if (state_reg == rtt_fd_pkg::ST_SQUARE)
            begin
                sqsum_reg <= sqsum_reg + rtt_fd_pkg::SQT_W'(sq_part);
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_delay_reg <= res_delay_reg;
            out_thr_reg   <= res_thr_reg;
        end
    end

    // Serial datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rtt_fd_pkg::ST_IDLE:
            begin
                // Load the square unit
                sqa_reg  <= rtt_fd_pkg::SQA_W'(in_sample);
                sqb_reg  <= in_sample;
                step_reg <= rtt_fd_pkg::STEP_W'(3);
            end
            rtt_fd_pkg::ST_SQUARE:
            begin
                sqa_reg  <= sqa_reg << rtt_fd_pkg::DIG_W;
                sqb_reg  <= sqb_reg >> rtt_fd_pkg::DIG_W;
                step_reg <= step_reg - 1'b1;
            end
            rtt_fd_pkg::ST_CHECK:
            begin
                nn_reg        <= 14'(count_reg) * 14'(count_reg);
                wu_reg        <= 15'(weight) * 15'(delay_unit_reg);
                res_delay_reg <= '0;
                res_thr_reg   <= 1'b0;
                // Load mean divide: total * 2^16 / n
                divq_reg    <= {total_reg, {(rtt_fd_pkg::DIVQ_W-rtt_fd_pkg::TOT_W){1'b0}}};
                rem_reg     <= '0;
                divisor_reg <= rtt_fd_pkg::DIVD_W'(count_reg);
                step_reg    <= rtt_fd_pkg::STEP_W'(rtt_fd_pkg::TOT_W + rtt_fd_pkg::FRAC_W - 1);
            end
            rtt_fd_pkg::ST_MEAN_DIV:
            begin
                divq_reg <= divq_step;
                rem_reg  <= rem_step;
                step_reg <= step_reg - 1'b1;
                if (step_done)
                begin
                    mean_reg  <= divq_step[31:0];
                    // Load n * sumsq
                    wacc_reg  <= '0;
                    msh_reg   <= rtt_fd_pkg::WACC_W'(sqsum_reg);
                    mbits_reg <= rtt_fd_pkg::MB_W'(count_reg);
                    step_reg  <= rtt_fd_pkg::STEP_W'(rtt_fd_pkg::CNT_W - 1);
                end
            end
            rtt_fd_pkg::ST_MUL_NS:
            begin
                wacc_reg  <= wacc_step;
                msh_reg   <= msh_reg << 1;
                mbits_reg <= mbits_reg >> 1;
                step_reg  <= step_reg - 1'b1;
                if (step_done)
                begin
                    // Load total^2 for subtraction
                    msh_reg   <= rtt_fd_pkg::WACC_W'(total_reg);
                    mbits_reg <= total_reg;
                    step_reg  <= rtt_fd_pkg::STEP_W'(rtt_fd_pkg::TOT_W - 1);
                end
            end
            rtt_fd_pkg::ST_MUL_TT:
            begin
                wacc_reg  <= wacc_step;
                msh_reg   <= msh_reg << 1;
                mbits_reg <= mbits_reg >> 1;
                step_reg  <= step_reg - 1'b1;
                if (step_done)
                begin
                    // Load variance divide: v * 2^32 / n^2
                    divq_reg    <= {wacc_step[45:0], 32'd0};
                    rem_reg     <= '0;
                    divisor_reg <= rtt_fd_pkg::DIVD_W'(nn_reg);
                    step_reg    <= rtt_fd_pkg::STEP_W'(rtt_fd_pkg::DIVQ_W - 1);
                end
            end
            rtt_fd_pkg::ST_VAR_DIV:
            begin
                divq_reg <= divq_step;
                rem_reg  <= rem_step;
                step_reg <= step_reg - 1'b1;
                if (step_done)
                begin
                    // Load square root
                    sqv_reg   <= divq_step[rtt_fd_pkg::ROOT_W-1:0];
                    sqres_reg <= '0;
                    sqbit_reg <= rtt_fd_pkg::ROOT_W'(1) << (rtt_fd_pkg::ROOT_W - 2);
                    step_reg  <= rtt_fd_pkg::STEP_W'(rtt_fd_pkg::ROOT_W / 2 - 1);
                end
            end
            rtt_fd_pkg::ST_SQRT:
            begin
                sqv_reg   <= sqv_step;
                sqres_reg <= sqres_step;
                sqbit_reg <= sqbit_reg >> 2;
                step_reg  <= step_reg - 1'b1;
                if (step_done)
                begin
                    dev_reg <= sqres_step[31:0];
                end
            end
            rtt_fd_pkg::ST_THRESH:
            begin
                // Load weight * unit * threshold
                wacc_reg  <= '0;
                msh_reg   <= rtt_fd_pkg::WACC_W'(thr[31:0]);
                mbits_reg <= rtt_fd_pkg::MB_W'(wu_reg);
                step_reg  <= rtt_fd_pkg::STEP_W'(14);
            end
            rtt_fd_pkg::ST_MUL_W:
            begin
                wacc_reg  <= wacc_step;
                msh_reg   <= msh_reg << 1;
                mbits_reg <= mbits_reg >> 1;
                step_reg  <= step_reg - 1'b1;
                if (step_done)
                begin
                    // Load delay divide: (product / 2^16) / target
                    divq_reg    <= {wacc_step[46:16], 47'd0};
                    rem_reg     <= '0;
                    divisor_reg <= target_reg;
                    step_reg    <= rtt_fd_pkg::STEP_W'(30);
                end
            end
            rtt_fd_pkg::ST_DLY_DIV:
            begin
                divq_reg <= divq_step;
                rem_reg  <= rem_step;
                step_reg <= step_reg - 1'b1;
                if (step_done)
                begin
                    res_delay_reg <= dly_capped;
                    res_thr_reg   <= 1'b1;
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A result appears only from the result step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rtt_fd_pkg::ST_RESULT))
        else $error("result loaded outside the result step");

    // The sample count never passes the peer limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rtt_fd_pkg::CNT_W'(rtt_fd_pkg::MAX_PEERS))
        else $error("sample count above peer limit");

    // The root scan bit stays a single bit while the root runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtt_fd_pkg::ST_SQRT) |-> $onehot(sqbit_reg))
        else $error("root scan bit lost");

    // The divider remainder stays below a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtt_fd_pkg::ST_MEAN_DIV || state_reg == rtt_fd_pkg::ST_VAR_DIV
         || state_reg == rtt_fd_pkg::ST_DLY_DIV) |-> (rem_reg < divisor_reg))
        else $error("divider remainder out of range");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the RTT fairness delay block.
module testbench;

    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_OFF_LEN  = 1500;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PEERS   = 90;

    // One peer item and one delay result
    typedef struct {
        logic signed [rtt_fd_pkg::RTT_W-1:0] rtt;
        logic                                stats;
        logic                                target;
        logic                                last;
    } peer_t;

    typedef struct {
        logic [15:0] delay;
        logic        throttled;
    } throttle_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [23:0]                      s_axis_tdata;   // rtt_ms[16:0], zero pad
    logic [1:0]                       s_axis_tuser;   // in_stats, is_target
    logic                             s_axis_tlast;   // last_peer
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [15:0]                      m_axis_tdata;   // delay_ms[15:0]
    logic [0:0]                       m_axis_tuser;   // throttled
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [rtt_fd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rtt_fd_pkg::CFG_DAT_W-1:0] cfg_data;

    // Shadow registers
    logic        cong_mode_q   = 1'b0;
    logic [6:0]  cong_users_q  = 7'd0;
    logic [7:0]  unit_q        = rtt_fd_pkg::DELAY_UNIT_RST;
    logic [15:0] max_delay_q   = rtt_fd_pkg::MAX_DELAY_RST;

    // Shadow run state
    logic [rtt_fd_pkg::CNT_W-1:0] run_count  = '0;
    logic [rtt_fd_pkg::TOT_W-1:0] run_sum    = '0;
    logic [rtt_fd_pkg::SQT_W-1:0] run_sqsum  = '0;
    logic [rtt_fd_pkg::MAG_W-1:0] run_target = 16'd1;

    throttle_t expected_delays[$];
    throttle_t oldest;

    int  error_count    = 0;
    int  runs_checked   = 0;
    int  throttled_seen = 0;
    int  peers_sent     = 0;
    int  settings_count = 0;
    int  hold_off_left  = 0;
    int  stall_left     = 0;
    bit  gaps_on        = 1'b1;
    bit  stalls_on      = 1'b1;

    rtt_fairness_delay u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Floor of the square root, bit by bit from the top
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (cand * cand <= x)
                root = cand;
        end
        return root;
    endfunction

    // Delay for the run held in the shadow state
    function automatic throttle_t fairness_delay();
        throttle_t   res;
        logic [63:0] n, t, s, mean, v, nn, q, r, var_q32, dev, weight, tgt, dly;
        longint      thr;
        res.delay     = '0;
        res.throttled = 1'b0;
        weight = cong_mode_q ? 64'(cong_users_q) : 64'd1;
        n      = 64'(run_count);
        if (n == 0 || weight == 0)
            return res;
        t       = 64'(run_sum);
        s       = 64'(run_sqsum);
        mean    = (t << rtt_fd_pkg::FRAC_W) / n;
        v       = n * s - t * t;
        nn      = n * n;
        q       = v / nn;
        r       = v % nn;
        var_q32 = (q << 32) + ((r << 32) / nn);
        dev     = root_floor(var_q32);
        thr     = longint'(mean) - longint'(dev);
        tgt     = 64'(run_target) << rtt_fd_pkg::FRAC_W;
        if (thr >= 0 && tgt <= 64'(thr))
        begin
            dly = (weight * 64'(thr) * 64'(unit_q)) / tgt;
            if (dly > 64'(max_delay_q))
                dly = 64'(max_delay_q);
            res.delay     = dly[15:0];
            res.throttled = 1'b1;
        end
        return res;
    endfunction

    // Fold one accepted peer into the shadow run; queue the delay on the last
    function automatic void absorb_peer(input peer_t p);
        logic [rtt_fd_pkg::MAG_W-1:0] mag;
        logic                         neg;
        logic [rtt_fd_pkg::MAG_W-1:0] sample;
        mag    = p.rtt[rtt_fd_pkg::MAG_W-1:0];
        neg    = p.rtt[rtt_fd_pkg::RTT_W-1];
        sample = neg ? '0 : mag;
        if (p.stats && run_count < rtt_fd_pkg::MAX_PEERS)
        begin
            run_count = run_count + 1'b1;
            run_sum   = run_sum + rtt_fd_pkg::TOT_W'(sample);
            run_sqsum = run_sqsum + rtt_fd_pkg::SQT_W'(sample) * rtt_fd_pkg::SQT_W'(sample);
        end
        if (p.target)
            run_target = (neg || mag == 0) ? 16'd1 : mag;
        if (p.last)
        begin
            expected_delays.insert(expected_delays.size(), fairness_delay());
            run_count  = '0;
            run_sum    = '0;
            run_sqsum  = '0;
            run_target = 16'd1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Send one peer item, with an occasional gap in front of it
    task automatic send_peer(input peer_t p);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, p.rtt};
        s_axis_tuser  <= {p.target, p.stats};
        s_axis_tlast  <= p.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_peer(p);
        peers_sent++;
    endtask

    task automatic send(input int rtt, input bit stats, input bit target, input bit last);
        peer_t p;
        p.rtt    = rtt_fd_pkg::RTT_W'(rtt);
        p.stats  = stats;
        p.target = target;
        p.last   = last;
        send_peer(p);
    endtask

    // Drop valid after the last item of a phase
    task automatic release_input();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
    endtask

    // Wait for every delay to come back, then let the block settle
    task automatic wait_drained();
        release_input();
        while (expected_delays.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rtt_fd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rtt_fd_pkg::CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rtt_fd_pkg::REG_CONG_MODE:  cong_mode_q  = value[0];
            rtt_fd_pkg::REG_CONG_USERS: cong_users_q = value[6:0];
            rtt_fd_pkg::REG_DELAY_UNIT: unit_q       = value[7:0];
            rtt_fd_pkg::REG_MAX_DELAY:  max_delay_q  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input int mode, input int users, input int unit,
                                  input int max_dly);
        write_reg(rtt_fd_pkg::REG_CONG_MODE,  rtt_fd_pkg::CFG_DAT_W'(mode));
        write_reg(rtt_fd_pkg::REG_CONG_USERS, rtt_fd_pkg::CFG_DAT_W'(users));
        write_reg(rtt_fd_pkg::REG_DELAY_UNIT, rtt_fd_pkg::CFG_DAT_W'(unit));
        write_reg(rtt_fd_pkg::REG_MAX_DELAY,  rtt_fd_pkg::CFG_DAT_W'(max_dly));
        settings_count++;
    endtask

    // One random run: clustered samples, mostly a target below the cluster
    task automatic send_random_run();
        int    len, base, spread, tpos, v;
        bit    long_run;
        peer_t p;
        long_run = ($urandom_range(0, 19) == 0);
        len      = long_run ? $urandom_range(60, 75) : $urandom_range(1, 12);
        base     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(1, 2000);
        spread   = $urandom_range(0, base / 4 + 1);
        tpos     = $urandom_range(0, len);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 19))
                0:       v = -1;
                1:       v = $urandom;
                2:       v = $urandom_range(0, 65535);
                default: v = base - spread + $urandom_range(0, 2 * spread);
            endcase
            if (v > 65535)
                v = 65535;
            p.rtt    = rtt_fd_pkg::RTT_W'(v);
            p.stats  = long_run || ($urandom_range(0, 9) != 0);
            p.target = (i == tpos) || ($urandom_range(0, 15) == 0);
            if (p.target && $urandom_range(0, 3) != 0)
                p.rtt = rtt_fd_pkg::RTT_W'($urandom_range(0, base / 2 + 1));
            p.last   = (i == len - 1);
            send_peer(p);
        end
    endtask

    // Hand-picked runs under the reset register values
    task automatic test_directed_runs();
        // equal samples, target below them
        send(100, 1, 0, 0);
        send(100, 1, 0, 0);
        send(50,  0, 1, 1);
        // largest samples, smallest target: capped
        send(65535, 1, 0, 0);
        send(65535, 1, 0, 0);
        send(1,     0, 1, 1);
        // no samples at all
        send(200, 0, 1, 1);
        // negative and zero times clamp
        send(-1,     1, 0, 0);
        send(-65536, 1, 0, 0);
        send(300,    1, 0, 0);
        send(0,      1, 1, 0);
        send(-1,     0, 0, 1);
        // no target: target time stays at one
        send(20, 1, 0, 0);
        send(20, 1, 0, 0);
        send(20, 1, 0, 1);
        // several targets: the last one counts
        send(500, 0, 1, 0);
        send(5,   0, 1, 0);
        send(30,  1, 0, 0);
        send(30,  1, 0, 1);
        // target above threshold
        send(10,   1, 0, 0);
        send(1000, 1, 0, 0);
        send(900,  0, 1, 1);
        // single item carrying every flag
        send(65535, 1, 1, 1);
        wait_drained();
    endtask

    // Register extremes, each with a short run
    task automatic test_register_extremes();
        // congestion mode with nobody congested
        apply_settings(1, 0, rtt_fd_pkg::DELAY_UNIT_RST, rtt_fd_pkg::MAX_DELAY_RST);
        send(50, 1, 0, 0);
        send(50, 1, 0, 0);
        send(10, 0, 1, 1);
        wait_drained();
        // weight 64 with the largest unit and cap
        apply_settings(1, 64, 255, 65535);
        send(100, 1, 0, 0);
        send(100, 1, 0, 0);
        send(1,   0, 1, 1);
        send(400, 1, 0, 0);
        send(420, 1, 0, 0);
        send(7,   1, 1, 1);
        wait_drained();
        // zero unit and zero cap
        apply_settings(0, 127, 0, 0);
        send(100, 1, 0, 0);
        send(50,  0, 1, 1);
        wait_drained();
        apply_settings(1, 1, 1, 65535);
        send(9000, 1, 0, 0);
        send(3,    0, 1, 1);
        wait_drained();
    endtask

    // Stall the result side long enough that the block backs up its input
    task automatic test_output_hold_off();
        apply_settings(0, 0, rtt_fd_pkg::DELAY_UNIT_RST, rtt_fd_pkg::MAX_DELAY_RST);
        hold_off_left = HOLD_OFF_LEN;
        for (int i = 0; i < 10; i++)
        begin
            send(200 + i, 1, 0, 0);
            send(40, 1, 1, 1);
        end
        wait_drained();
    endtask

    // Random settings and random runs; the final phase has no idling
    task automatic test_random_runs();
        int phase_start;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == RANDOM_PHASES - 1)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            apply_settings($urandom_range(0, 1),
                           ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 64),
                           $urandom_range(1, 255),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(100, 5000));
            phase_start = peers_sent;
            while (peers_sent - phase_start < PHASE_PEERS)
                send_random_run();
            wait_drained();
        end
    endtask

    // Result side: long hold-off, random stall bursts, otherwise ready
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_left--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected delay
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_delays.size() == 0)
                report_mismatch($sformatf("unexpected result delay=%0d throttled=%0b",
                                          m_axis_tdata, m_axis_tuser[0]));
            else
            begin
                oldest = expected_delays.pop_front();
                runs_checked++;
                if (oldest.throttled)
                    throttled_seen++;
                if (m_axis_tdata !== oldest.delay)
                    report_mismatch($sformatf("run %0d delay %0d, want %0d",
                                              runs_checked, m_axis_tdata, oldest.delay));
                if (m_axis_tuser[0] !== oldest.throttled)
                    report_mismatch($sformatf("run %0d throttled %0b, want %0b",
                                              runs_checked, m_axis_tuser[0],
                                              oldest.throttled));
            end
        end
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("[rtt_fairness_delay] ERROR");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = rtt_fd_pkg::REG_CONG_MODE;
        cfg_data      = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_directed_runs();
        test_register_extremes();
        test_output_hold_off();
        test_random_runs();

        $display("Checked %0d delay results (%0d throttled) from %0d peer items",
                 runs_checked, throttled_seen, peers_sent);
        $display("Swept %0d register settings, with one long result-side stall",
                 settings_count);
        if (error_count == 0)
            $display("[rtt_fairness_delay] OK");
        else
            $display("[rtt_fairness_delay] ERROR");
        $finish;
    end

endmodule
